/* rtl/tmwf_pkg.sv */
package tmwf_pkg;

  // Sample and result width, fixed by the stream format
  localparam int unsigned DATA_W = 16;
  // Samples dropped from the window: one minimum, one maximum
  localparam int unsigned TRIM_COUNT = 2;
  // Result value while the window is still filling
  localparam logic [DATA_W-1:0] WARMUP_MARKER = 16'd8;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_TRIM,
    ST_DIV,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // store the incoming sample, advance pointers
    logic scan_start;  // clear accumulators, rewind read index
    logic scan_rd;     // read one ring entry
    logic trim;        // form trimmed sum
    logic div_step;    // quotient through the reciprocal multiply
    logic load_out;    // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic going_full;  // the sample being accepted completes the window
    logic scan_last;   // read index is at the last ring entry
    logic out_free;    // output register can take a new result
  } status_t;

endpackage

/* rtl/tmwf_ctrl.sv */
module tmwf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tmwf_pkg::status_t sts,
  output logic              in_ready,
  output tmwf_pkg::cmd_t    cmd
);

  tmwf_pkg::state_t state_r;
  tmwf_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmwf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmwf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.going_full ? tmwf_pkg::ST_SCAN : tmwf_pkg::ST_OUT;
        end
      end
      tmwf_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = tmwf_pkg::ST_SCAN_END;
        end
      end
      tmwf_pkg::ST_SCAN_END: state_nxt = tmwf_pkg::ST_TRIM;
      tmwf_pkg::ST_TRIM:     state_nxt = tmwf_pkg::ST_DIV;
      tmwf_pkg::ST_DIV:      state_nxt = tmwf_pkg::ST_OUT;
      tmwf_pkg::ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = tmwf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tmwf_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      tmwf_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.accept     = in_valid;
        cmd.scan_start = in_valid & sts.going_full;
      end
      tmwf_pkg::ST_SCAN: cmd.scan_rd  = 1'b1;
      tmwf_pkg::ST_TRIM: cmd.trim     = 1'b1;
      tmwf_pkg::ST_DIV:  cmd.div_step = 1'b1;
      tmwf_pkg::ST_OUT:  cmd.load_out = sts.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/tmwf_dp.sv */
module tmwf_dp #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tmwf_pkg::cmd_t              cmd,
  input  logic [tmwf_pkg::DATA_W-1:0] sample,
  input  logic                        out_ready,
  output tmwf_pkg::status_t           sts,
  output logic                        out_valid,
  output logic [tmwf_pkg::DATA_W-1:0] filtered,
  output logic                        ready_res
);

  localparam int unsigned DW      = tmwf_pkg::DATA_W;
  localparam int unsigned AW      = $clog2(WINDOW);
  localparam int unsigned SUM_W   = DW + AW;
  localparam int unsigned DIVISOR = WINDOW - tmwf_pkg::TRIM_COUNT;
  // Reciprocal ceil(2^SHIFT / DIVISOR), exact floor for any SUM_W-bit dividend
  localparam int unsigned DIV_L   = $clog2(DIVISOR);
  localparam int unsigned SHIFT   = SUM_W + DIV_L;
  localparam int unsigned PROD_W  = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam logic [AW-1:0]    LAST_IDX = AW'(WINDOW - 1);
  localparam logic [AW:0]      FILL_MAX = (AW + 1)'(WINDOW);

  // Sample ring
  logic [DW-1:0] ring_mem [WINDOW];
  logic [DW-1:0] rd_data_r;

  logic [AW-1:0] wr_ptr_r;
  logic [AW:0]   fill_r;
  logic          mean_r;

  logic [AW-1:0] scan_idx_r;
  logic          rd_vld_r;
  logic [SUM_W-1:0] sum_r;
  logic [DW-1:0]    min_r;
  logic [DW-1:0]    max_r;

  logic [SUM_W-1:0]  trim_sum_r;
  logic [PROD_W-1:0] div_prod;
  logic [DW-1:0]     quo_r;

  logic          out_vld_r;
  logic [DW-1:0] out_data_r;
  logic          out_flag_r;

  // Ring write on accept, registered read during the scan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_mem[wr_ptr_r] <= sample;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= ring_mem[scan_idx_r];
    end
  end

  // Write pointer and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (cmd.accept) begin
      wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      if (fill_r != FILL_MAX) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign sts.going_full = (fill_r >= FILL_MAX - 1'b1);

  // Result kind of the item in flight
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mean_r <= sts.going_full;
    end
  end

  // Read index and read-data valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_rd && scan_idx_r != LAST_IDX) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  assign sts.scan_last = (scan_idx_r == LAST_IDX);

  // Sum, minimum and maximum over the window
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      sum_r <= '0;
      min_r <= '1;
      max_r <= '0;
    end else if (rd_vld_r) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
      if (rd_data_r < min_r) begin
        min_r <= rd_data_r;
      end
      if (rd_data_r > max_r) begin
        max_r <= rd_data_r;
      end
    end
  end

  // Divide by the constant: the trimmed sum is registered, then the reciprocal multiply follows in the next cycle
  assign div_prod = PROD_W'(trim_sum_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      trim_sum_r <= sum_r - SUM_W'(min_r) - SUM_W'(max_r);
    end
    if (cmd.div_step) begin
      quo_r <= div_prod[SHIFT +: DW];
    end
  end

  // Output register
  assign sts.out_free = ~out_vld_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= mean_r ? quo_r : tmwf_pkg::WARMUP_MARKER;
      out_flag_r <= mean_r;
    end
  end

  assign out_valid = out_vld_r;
  assign filtered  = out_data_r;
  assign ready_res = out_flag_r;

endmodule

/* rtl/trimmed_mean_window_filter_unit.sv */
// Sliding-window trimmed-mean filter.
// Input stream (in_*): one unsigned 16-bit sample per request on in_tdata.
// Result stream (out_*): one result per sample. out_tdata carries the
// filtered value, out_tuser is high once the window is full and the value is
// the trimmed mean; before that out_tdata is the warm-up marker 8.
// The newest WINDOW samples sit in a ring memory. Each sample after warm-up
// starts a scan of the ring, one entry per cycle through the memory read
// port, for sum, minimum and maximum, then the trimmed sum is divided by
// WINDOW-2 with one multiply by a constant reciprocal.
// Once the window is full the ring scan sets the pace of the stream; warm-up
// samples skip the scan and the divide. A new sample is taken only after
// the current one's result has been loaded into the output register.
// in_tready is high only while no sample is in work, but a finished result
// waiting in the output register does not block the next sample. If the
// receiver stalls, the next result waits in the controller until the
// output register drains.
// Reset (rst_n low, synchronous) empties the window and drops any pending
// result; the first WINDOW-1 samples after reset answer with the marker.
module trimmed_mean_window_filter_unit #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tmwf_pkg::DATA_W-1:0] in_tdata,   // [15:0] sample
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tmwf_pkg::DATA_W-1:0] out_tdata,  // [15:0] filtered
  output logic                        out_tuser   // [0] ready_res
);

  tmwf_pkg::cmd_t    cmd;
  tmwf_pkg::status_t sts;

  tmwf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  tmwf_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sample    (in_tdata),
    .out_ready (out_tready),
    .sts       (sts),
    .out_valid (out_tvalid),
    .filtered  (out_tdata),
    .ready_res (out_tuser)
  );

  // One sample in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a sample is in work");

  // A result never overwrites one that is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("output register overwritten");

  // Warm-up results carry the marker
  a_warmup_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == tmwf_pkg::WARMUP_MARKER))
    else $error("warm-up result without marker");

  // Divider runs only while the input side is closed
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.scan_rd) |-> !in_tready)
    else $error("input open during scan or divide");

endmodule

/* dv/trimmed_mean_window_filter_unit_checker.sv */
`timescale 1ns / 1ps

// Watches both streams, keeps its own copy of the sample window and compares
// every result request against the oldest predicted result, marker or trimmed mean.
module trimmed_mean_window_filter_unit_checker #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [tmwf_pkg::DATA_W-1:0] in_tdata,   // [15:0] sample
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [tmwf_pkg::DATA_W-1:0] out_tdata,  // [15:0] filtered
  input  logic                        out_tuser,  // [0] ready_res
  output int                          fail_count,
  output int                          pending,
  output int                          results_seen
);

  localparam int unsigned DW = tmwf_pkg::DATA_W;

  typedef struct packed {
    logic [DW-1:0] filtered;
    logic          ready_res;
  } mean_result_t;

  // Shadow window state
  logic [DW-1:0] shadow_ring [WINDOW];
  int unsigned   shadow_wr;
  int unsigned   shadow_fill;
  mean_result_t  expected_means [$];
  int            mismatches;
  int            checked;

  // Store one sample and work out the result it causes
  function automatic mean_result_t advance_window(input logic [DW-1:0] s);
    mean_result_t  r;
    logic [31:0]   total;
    logic [DW-1:0] lo;
    logic [DW-1:0] hi;
    int unsigned   k;
    shadow_ring[shadow_wr] = s;
    shadow_wr = (shadow_wr + 1 >= WINDOW) ? 0 : shadow_wr + 1;
    if (shadow_fill < WINDOW) shadow_fill++;
    if (shadow_fill < WINDOW) begin
      r.filtered  = tmwf_pkg::WARMUP_MARKER;
      r.ready_res = 1'b0;
    end else begin
      total = '0;
      lo    = shadow_ring[0];
      hi    = shadow_ring[0];
      for (k = 0; k < WINDOW; k++) begin
        total += 32'(shadow_ring[k]);
        if (shadow_ring[k] < lo) lo = shadow_ring[k];
        if (shadow_ring[k] > hi) hi = shadow_ring[k];
      end
      total       = total - 32'(lo) - 32'(hi);
      r.filtered  = DW'(total / (WINDOW - tmwf_pkg::TRIM_COUNT));
      r.ready_res = 1'b1;
    end
    return r;
  endfunction

  // Predict on accepted samples, compare on accepted results
  always @(posedge clk) begin
    mean_result_t exp_r;
    if (!rst_n) begin
      shadow_wr   = 0;
      shadow_fill = 0;
      expected_means.delete();
      mismatches  = 0;
      checked     = 0;
    end else begin
      if (in_tvalid && in_tready) expected_means.push_back(advance_window(in_tdata));
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_means.size() == 0) begin
          $display("%0t: result with nothing expected: filtered=%0d ready_res=%0b",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          exp_r = expected_means.pop_front();
          if (out_tdata !== exp_r.filtered) begin
            $display("%0t: filtered mismatch: expected %0d, actual %0d",
                     $time, exp_r.filtered, out_tdata);
            mismatches++;
          end
          if (out_tuser !== exp_r.ready_res) begin
            $display("%0t: ready_res mismatch: expected %0b, actual %0b",
                     $time, exp_r.ready_res, out_tuser);
            mismatches++;
          end
        end
      end
    end
    fail_count   <= mismatches;
    pending      <= expected_means.size();
    results_seen <= checked;
  end

endmodule

/* dv/trimmed_mean_window_filter_unit_tb.sv */
`timescale 1ns / 1ps

module trimmed_mean_window_filter_unit_tb;

  localparam int unsigned DW          = tmwf_pkg::DATA_W;
  localparam int unsigned WINDOW      = 20;
  localparam int          DIRECTED_N  = 25;
  localparam int          RANDOM_N    = 500;
  localparam int          HOLD_AT     = 200;   // sample count that triggers the long stall
  localparam int          DRAIN_AT    = 350;   // sample count where the sender waits for drain
  localparam int          TAIL_AT     = DIRECTED_N + RANDOM_N - 60;
  localparam int          HOLD_CYCLES = 400;
  localparam int          SETTLE      = WINDOW + 40;
  localparam int          LIMIT       = 400000;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [DW-1:0] in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [DW-1:0] out_tdata;
  logic          out_tuser;

  int fail_count;
  int pending;
  int results_seen;
  int samples_sent;
  int cycle_cnt;
  bit hold_req;
  bit hold_done;
  bit tail_mode;

  trimmed_mean_window_filter_unit #(.WINDOW(WINDOW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  trimmed_mean_window_filter_unit_checker #(.WINDOW(WINDOW)) mean_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_cnt,
             pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one sample and hold it until the block takes the request
  task automatic send_sample(input logic [DW-1:0] s);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Input idle burst; data wiggles while valid is low
  task automatic idle_input(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tdata  <= DW'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Random gap between samples, none in the tail
  task automatic maybe_gap();
    if (!tail_mode && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 18));
  endtask

  // Sample picker: half full range, half near or at the rails
  function automatic logic [DW-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return DW'($urandom_range(0, 15));
      1:       return DW'(16'hFFFF - $urandom_range(0, 15));
      2:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      default: return DW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: short random stalls, one long hold, always ready in the tail
  initial begin
    int n;
    int hold_cnt;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    @(posedge rst_n);
    forever begin
      if (tail_mode) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end else if (hold_req && !hold_done) begin
        @(negedge clk);
        out_tready <= 1'b0;
        for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        // Optional random stall, always followed by a ready stretch
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, 18);
          @(negedge clk);
          out_tready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
        n = $urandom_range(1, 40);
        @(negedge clk);
        out_tready <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int run_len;
    int i;
    logic [DW-1:0] run_val;
    logic const_run;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    hold_req     = 1'b0;
    tail_mode    = 1'b0;
    samples_sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Warm-up with full-scale samples until the window is full at the top rail
    for (i = 0; i < WINDOW; i++) begin
      send_sample(16'hFFFF);
      maybe_gap();
    end
    // Rail and alternating bit patterns entering a full window
    send_sample(16'h0000);
    send_sample(16'h0001);
    maybe_gap();
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    maybe_gap();
    send_sample(16'h8000);

    // Let the directed part drain before going random
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // Random runs: mixed samples, with occasional constant runs covering a window
    while (samples_sent < DIRECTED_N + RANDOM_N) begin
      const_run = ($urandom_range(0, 9) == 0);
      if (const_run) begin
        run_len = $urandom_range(WINDOW, WINDOW + 4);
        case ($urandom_range(0, 2))
          0:       run_val = 16'h0000;
          1:       run_val = 16'hFFFF;
          default: run_val = DW'($urandom_range(0, 65535));
        endcase
      end else begin
        run_len = $urandom_range(1, 8);
      end
      for (i = 0; i < run_len; i++) begin
        if (samples_sent == HOLD_AT) hold_req = 1'b1;
        if (samples_sent == DRAIN_AT) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
        if (samples_sent >= TAIL_AT) tail_mode = 1'b1;
        send_sample(const_run ? run_val : pick_sample());
        maybe_gap();
      end
    end

    // Drain and settle
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Summary: %0d samples (%0d directed), %0d results checked,", samples_sent,
             DIRECTED_N, results_seen);
    $display("  warm-up, rail windows, long output stall and full drain pauses covered");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
